// ===== rtl/lz77wd_pkg.sv =====
package lz77wd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int SIZE_W       = 24;
  localparam int DIST_W       = PTR_W + 1;
  localparam int LEN_W        = 5;
  localparam int LEN_BIAS     = 3;
  localparam int HDR_IDX_W    = 2;
  localparam int FLAG_POS_W   = 3;

  typedef enum logic {
    CMD_LITERAL,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    logic                valid;
    logic                restart;
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   lit;
    logic [LEN_W-1:0]    len;
    logic [DIST_W-1:0]   back_dist;
    logic [SIZE_W-1:0]   target;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic reached;
  } eng_sts_t;

endpackage

// ===== rtl/lz77wd_copy_engine.sv =====
module lz77wd_copy_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lz77wd_pkg::cmd_t           cmd,
  output lz77wd_pkg::eng_sts_t       sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lz77wd_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_run_last,
  output logic                       out_stream_end,
  output logic                       out_bad_reference
);
  import lz77wd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fin;
    logic              bad;
  } out_ent_t;

  logic [BYTE_W-1:0] hist_mem [WINDOW_DEPTH];

  logic              act_r;
  logic              is_copy_r;
  logic [BYTE_W-1:0] lit_r;
  logic [LEN_W-1:0]  rem_r;
  logic [DIST_W-1:0] dist_r;
  logic [SIZE_W-1:0] target_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [SIZE_W-1:0] prod_r;

  logic              w_vld_r;
  logic              w_lit_sel_r;
  logic              w_fwd_r;
  logic              w_bad_r;
  logic              w_last_r;
  logic              w_end_r;
  logic [BYTE_W-1:0] w_lit_r;
  logic [PTR_W-1:0]  w_addr_r;
  logic [BYTE_W-1:0] rd_q_r;
  logic [BYTE_W-1:0] fwd_data_r;

  out_ent_t          q_ent [2];
  logic [1:0]        occ_r;
  logic              wp_r;
  logic              rp_r;

  logic              pop;
  logic [2:0]        occ_after;
  logic              credit_ok;
  logic              issue;
  logic [PTR_W-1:0]  src;
  logic              bad;
  logic [SIZE_W-1:0] prod_inc;
  logic              reached;
  logic              last;
  logic [BYTE_W-1:0] wd;
  out_ent_t          head;

  assign pop       = out_valid && !out_stall;
  assign occ_after = {1'b0, occ_r} + {2'b00, w_vld_r} - {2'b00, pop};
  assign credit_ok = (occ_after <= 3'd1);
  assign issue     = act_r && credit_ok;

  assign src      = ptr_r - dist_r[PTR_W-1:0];
  assign bad      = is_copy_r && ({{(SIZE_W-DIST_W){1'b0}}, dist_r} > prod_r);
  assign prod_inc = prod_r + SIZE_W'(1);
  assign reached  = (prod_inc >= target_r);
  assign last     = !is_copy_r || (rem_r == LEN_W'(1)) || reached;

  assign sts.fin     = issue && last;
  assign sts.reached = reached;

  always_comb begin
    if (w_bad_r) begin
      wd = '0;
    end else if (w_lit_sel_r) begin
      wd = w_lit_r;
    end else if (w_fwd_r) begin
      wd = fwd_data_r;
    end else begin
      wd = rd_q_r;
    end
  end

  assign head              = q_ent[rp_r];
  assign out_valid         = (occ_r != 2'd0);
  assign out_byte          = head.data;
  assign out_run_last      = head.last;
  assign out_stream_end    = head.fin;
  assign out_bad_reference = head.bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      ptr_r   <= '0;
      prod_r  <= '0;
      w_vld_r <= 1'b0;
      occ_r   <= 2'd0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
    end else begin
      w_vld_r <= issue;
      occ_r   <= occ_after[1:0];
      if (w_vld_r) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (cmd.restart) begin
        ptr_r  <= '0;
        prod_r <= '0;
      end else if (issue) begin
        ptr_r  <= ptr_r + PTR_W'(1);
        prod_r <= prod_inc;
      end
      if (cmd.valid) begin
        act_r <= 1'b1;
      end else if (issue && last) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      is_copy_r <= (cmd.kind == CMD_COPY);
      lit_r     <= cmd.lit;
      rem_r     <= cmd.len;
      dist_r    <= cmd.back_dist;
      target_r  <= cmd.target;
    end else if (issue) begin
      rem_r <= rem_r - LEN_W'(1);
    end
    if (issue) begin
      rd_q_r      <= hist_mem[src];
      w_fwd_r     <= w_vld_r && (w_addr_r == src);
      fwd_data_r  <= wd;
      w_lit_sel_r <= !is_copy_r;
      w_lit_r     <= lit_r;
      w_bad_r     <= bad;
      w_last_r    <= last;
      w_end_r     <= reached;
      w_addr_r    <= ptr_r;
    end
    if (w_vld_r) begin
      hist_mem[w_addr_r] <= wd;
      q_ent[wp_r]        <= '{data: wd, last: w_last_r, fin: w_end_r, bad: w_bad_r};
    end
  end

endmodule

// ===== rtl/lz77_window_decoder_unit.sv =====
// LZ77 decoder with a 4096-byte history window. Feed the compressed stream one
// word at a time, with in_start_req set on the first header word; four header
// words (type, then a 24-bit output size, low byte first), flag words and the
// first word of a back-reference are taken without a stall. After a literal
// word, or the second word of a back-reference that yields n bytes, in_stall
// stays high while the engine writes those bytes, one output word per cycle
// while out_stall is low, paced by the single read port of the history memory
// and a two-entry output queue. The history needs no clearing after reset. A
// reference reaching before the stream start gives zero with out_bad_reference
// set; words after the declared size are dropped until the next start.
module lz77_window_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lz77wd_pkg::BYTE_W-1:0] in_byte,
  input  logic                          in_start_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lz77wd_pkg::BYTE_W-1:0] out_byte,
  output logic                          out_run_last,
  output logic                          out_stream_end,
  output logic                          out_bad_reference
);
  import lz77wd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_ITEM,
    PH_REF2,
    PH_EXEC,
    PH_DONE
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0]  hidx_r, hidx_nxt;
  logic [SIZE_W-1:0]     target_r, target_nxt;
  logic [BYTE_W-1:0]     flags_r, flags_nxt;
  logic [FLAG_POS_W-1:0] fpos_r, fpos_nxt;
  logic [BYTE_W-1:0]     ref1_r, ref1_nxt;

  logic                  acc;
  cmd_t                  cmd;
  eng_sts_t              sts;

  assign in_stall = (phase_r == PH_EXEC);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    phase_t               eph;
    logic [HDR_IDX_W-1:0] ehidx;
    logic [SIZE_W-1:0]    etgt;
    eph        = in_start_req ? PH_HEADER : phase_r;
    ehidx      = in_start_req ? '0 : hidx_r;
    etgt       = in_start_req ? '0 : target_r;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    target_nxt = target_r;
    flags_nxt  = flags_r;
    fpos_nxt   = fpos_r;
    ref1_nxt   = ref1_r;
    cmd           = '0;
    cmd.kind      = CMD_LITERAL;
    cmd.restart   = acc && in_start_req;
    cmd.lit       = in_byte;
    cmd.len       = {1'b0, ref1_r[7:4]} + LEN_W'(LEN_BIAS);
    cmd.back_dist = {1'b0, ref1_r[3:0], in_byte} + DIST_W'(1);
    cmd.target    = target_r;
    if (acc) begin
      if (in_start_req) begin
        flags_nxt = '0;
        fpos_nxt  = '1;
        ref1_nxt  = '0;
      end
      case (eph)
        PH_HEADER: begin
          target_nxt = etgt;
          case (ehidx)
            2'd1:    target_nxt[7:0]   = etgt[7:0] | in_byte;
            2'd2:    target_nxt[15:8]  = etgt[15:8] | in_byte;
            2'd3:    target_nxt[23:16] = etgt[23:16] | in_byte;
            default: target_nxt        = etgt;
          endcase
          if (ehidx == 2'd3) begin
            hidx_nxt  = '0;
            phase_nxt = (target_nxt == '0) ? PH_DONE : PH_FLAG;
          end else begin
            hidx_nxt  = ehidx + HDR_IDX_W'(1);
            phase_nxt = PH_HEADER;
          end
        end
        PH_FLAG: begin
          flags_nxt = in_byte;
          fpos_nxt  = '1;
          phase_nxt = PH_ITEM;
        end
        PH_ITEM: begin
          if (flags_r[fpos_r]) begin
            ref1_nxt  = in_byte;
            phase_nxt = PH_REF2;
          end else begin
            cmd.valid = 1'b1;
            phase_nxt = PH_EXEC;
          end
        end
        PH_REF2: begin
          cmd.valid = 1'b1;
          cmd.kind  = CMD_COPY;
          phase_nxt = PH_EXEC;
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end else if (phase_r == PH_EXEC && sts.fin) begin
      if (sts.reached) begin
        phase_nxt = PH_DONE;
      end else if (fpos_r == '0) begin
        phase_nxt = PH_FLAG;
      end else begin
        fpos_nxt  = fpos_r - FLAG_POS_W'(1);
        phase_nxt = PH_ITEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hidx_r   <= '0;
      target_r <= '0;
      flags_r  <= '0;
      fpos_r   <= '1;
      ref1_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      target_r <= target_nxt;
      flags_r  <= flags_nxt;
      fpos_r   <= fpos_nxt;
      ref1_r   <= ref1_nxt;
    end
  end

  lz77wd_copy_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_stream_end    (out_stream_end),
    .out_bad_reference (out_bad_reference)
  );

`ifndef SYNTH
  a_fin_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fin |-> phase_r == PH_EXEC)
    else $error("engine finished outside exec phase");

  a_cmd_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.valid |=> phase_r == PH_EXEC)
    else $error("command issued without entering exec phase");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_reference |-> out_byte == '0)
    else $error("bad reference word not zero");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_last)
    else $error("stream end on a word that is not last of its run");
`endif

endmodule
